### src/tdfs_pkg.sv
// Shared constants, types and helper functions of the thermal delta frame statistics block.
package tdfs_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int GRID_W     = 9;
   localparam int DELTA_W    = 17;
   localparam int LUMA_W     = 16;
   localparam int STAT_W     = 16;
   localparam int DIFF_W     = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DAT_W  = 17;
   localparam int DIV_NW     = 49;
   localparam int DIV_DW     = 18;
   localparam int SQRT_IW    = 50;
   localparam int SQRT_RW    = SQRT_IW / 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH   = 3'd0,
      REG_GRID_HEIGHT  = 3'd1,
      REG_POLARITY     = 3'd2,
      REG_MIN_DELTA    = 3'd3,
      REG_SPREAD_FLOOR = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic              ok;
      logic [DIFF_W-1:0] diff;
   } pair_type;

   function automatic pair_type pair_test(input logic signed [DELTA_W-1:0] a,
                                          input logic signed [DELTA_W-1:0] b,
                                          input logic signed [DELTA_W-1:0] floor_val);
      logic signed [DELTA_W-1:0] hi;
      logic signed [DELTA_W-1:0] lo;
      logic signed [DELTA_W-1:0] lim;
      logic signed [22:0]        lhs;
      logic signed [22:0]        rhs;
      pair_type                  res;
      hi  = (a > b) ? a : b;
      lo  = (a > b) ? b : a;
      lim = (hi > 17'sd256) ? hi : 17'sd256;
      lhs = 23'(lo) * 23'sd25;
      rhs = 23'(lim) * 23'sd18;
      res.ok   = (a >= floor_val) && (b >= floor_val) && (lhs >= rhs);
      res.diff = DIFF_W'(hi) - DIFF_W'(lo);
      return res;
   endfunction

   function automatic logic [STAT_W-1:0] sat16(input logic [SQRT_RW-1:0] v);
      return (|v[SQRT_RW-1:STAT_W]) ? {STAT_W{1'b1}} : v[STAT_W-1:0];
   endfunction

endpackage

### src/tdfs_if.sv
// Channel interfaces: cell input, result output and register write.
interface tdfs_req_if;
   import tdfs_pkg::*;
   logic              valid;
   logic              ready;
   logic [LUMA_W-1:0] background_luma;
   logic [LUMA_W-1:0] current_luma;
   modport source (output valid, background_luma, current_luma, input ready);
   modport sink   (input valid, background_luma, current_luma, output ready);
endinterface

interface tdfs_rsp_if;
   import tdfs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DELTA_W-1:0] cell_delta;
   logic                      stats_valid;
   logic [DELTA_W-1:0]        positive_count;
   logic [STAT_W-1:0]         pos_mean;
   logic [STAT_W-1:0]         pos_spread;
   logic [STAT_W-1:0]         contrast_mean;
   logic [STAT_W-1:0]         contrast_std;
   modport source (output valid, cell_delta, stats_valid, positive_count, pos_mean,
                   pos_spread, contrast_mean, contrast_std, input ready);
   modport sink   (input valid, cell_delta, stats_valid, positive_count, pos_mean,
                   pos_spread, contrast_mean, contrast_std, output ready);
endinterface

interface tdfs_csr_if;
   import tdfs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/tdfs_div.sv
// Restoring divider, one quotient bit per cycle.
module tdfs_div
   import tdfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic              done,
   output logic [DIV_NW-1:0] quotient
);
   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic [DIV_DW-1:0] rem_ff;
   logic [DIV_NW-1:0] quo_ff;
   logic [DIV_DW-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DIV_DW:0]   shifted;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DIV_NW-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIV_NW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fits ? DIV_DW'(shifted - {1'b0, dvs_ff}) : shifted[DIV_DW-1:0];
         quo_ff <= {quo_ff[DIV_NW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### src/tdfs_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module tdfs_isqrt
   import tdfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SQRT_IW-1:0] radicand,
   output logic               done,
   output logic [SQRT_RW-1:0] root
);
   localparam int CNT_W = $clog2(SQRT_RW + 1);
   localparam int REM_W = SQRT_RW + 2;

   logic [SQRT_IW-1:0] x_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [SQRT_RW-1:0] root_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff;
   logic               done_ff;
   logic [REM_W-1:0]   r4;
   logic [REM_W-1:0]   trial;

   assign r4    = {rem_ff[REM_W-3:0], x_ff[SQRT_IW-1:SQRT_IW-2]};
   assign trial = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(SQRT_RW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         x_ff <= {x_ff[SQRT_IW-3:0], 2'b00};
         if (r4 >= trial) begin
            rem_ff  <= r4 - trial;
            root_ff <= {root_ff[SQRT_RW-2:0], 1'b1};
         end else begin
            rem_ff  <= r4;
            root_ff <= {root_ff[SQRT_RW-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

### src/thermal_delta_frame_stats_core.sv
// Thermal delta frame statistics core: per-cell delta, pair contrast and frame statistics.
//
// Usage:
//   req_bus carries one cell (background and current luma, Q8.8) per transfer, in raster
//   order. rsp_bus returns one result per cell: the signed delta, and on the last cell
//   of the frame the positive-delta and pair-contrast statistics. csr_bus writes the
//   grid size, polarity, pair threshold and deviation floor; write only while idle.
//   Processing:
//   An ordinary cell passes from transfer to result register through a pair evaluation
//   with row-store write-back, the states SQ0 to SQ3 of the shared squaring multiplier
//   and an output state. The last cell of a frame adds, for each of the two statistic
//   sets, two divisions with their start states, a squaring state and a square root
//   with its start state.
//   The next cell is taken once the previous one has left the datapath. The row store
//   holds the previous row's deltas in one synchronous RAM.
//   Reset returns registers to defaults and starts a fresh frame; the row store
//   is not cleared. A stalled receiver holds the result register; one further cell
//   is processed and waits for the register to empty.
module thermal_delta_frame_stats_core
   import tdfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   tdfs_req_if.sink     req_bus,
   tdfs_rsp_if.source   rsp_bus,
   tdfs_csr_if.sink     csr_bus
);
   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_READ    = 14'b00000000000010,
      ST_SQ0     = 14'b00000000000100,
      ST_SQ1     = 14'b00000000001000,
      ST_SQ2     = 14'b00000000010000,
      ST_SQ3     = 14'b00000000100000,
      ST_MDIV_GO = 14'b00000001000000,
      ST_MDIV    = 14'b00000010000000,
      ST_QDIV_GO = 14'b00000100000000,
      ST_QDIV    = 14'b00001000000000,
      ST_MUL     = 14'b00010000000000,
      ST_ROOT_GO = 14'b00100000000000,
      ST_ROOT    = 14'b01000000000000,
      ST_OUT     = 14'b10000000000000
   } state_type;

   state_type state_ff;

   logic [GRID_W-1:0]         grid_width_ff;
   logic [GRID_W-1:0]         grid_height_ff;
   logic                      polarity_ff;
   logic signed [DELTA_W-1:0] min_delta_ff;
   logic [STAT_W-1:0]         spread_floor_ff;

   logic signed [DELTA_W-1:0] row_mem [MAX_WIDTH];
   logic signed [DELTA_W-1:0] up_ff;
   logic signed [DELTA_W-1:0] d_ff;
   logic signed [DELTA_W-1:0] left_ff;
   logic [COL_W-1:0]          col_ff;
   logic [ROW_W-1:0]          row_ff;
   logic                      last_ff;

   logic [31:0]               pos_sum_ff;
   logic [47:0]               pos_sq_ff;
   logic [DELTA_W-1:0]        pos_cnt_ff;
   logic [32:0]               pair_sum_ff;
   logic [48:0]               pair_sq_ff;
   logic [DIFF_W-1:0]         pair_cnt_ff;

   logic                      left_ok_ff;
   logic                      up_ok_ff;
   logic [DIFF_W-1:0]         left_diff_ff;
   logic [DIFF_W-1:0]         up_diff_ff;
   logic [2*DIFF_W-1:0]       prod_ff;
   logic [DIFF_W-1:0]         mul_a;

   logic                      sel_ff;
   logic [DIFF_W-1:0]         mean_ff;
   logic [DIV_NW-1:0]         ex2_ff;
   logic [DIV_NW-1:0]         var_ff;
   logic [STAT_W-1:0]         dmean_ff;
   logic [STAT_W-1:0]         dnorm_ff;
   logic [STAT_W-1:0]         cmean_ff;
   logic [STAT_W-1:0]         cstd_ff;

   logic                      rsp_valid_ff;
   logic signed [DELTA_W-1:0] rsp_delta_ff;
   logic                      rsp_stats_ff;
   logic [DELTA_W-1:0]        rsp_count_ff;
   logic [STAT_W-1:0]         rsp_dmean_ff;
   logic [STAT_W-1:0]         rsp_dnorm_ff;
   logic [STAT_W-1:0]         rsp_cmean_ff;
   logic [STAT_W-1:0]         rsp_cstd_ff;

   logic                      req_xfer;
   logic signed [DELTA_W-1:0] d_in;
   pair_type                  left_pair;
   pair_type                  up_pair;
   logic                      left_use;
   logic                      up_use;
   logic [GRID_W-1:0]         w_eff;
   logic [GRID_W-1:0]         h_eff;
   logic                      row_end;
   logic                      frame_end;
   logic [DIV_NW-1:0]         sum_sel;
   logic [DIV_NW-1:0]         sq_sel;
   logic [DIFF_W-1:0]         n_sel;
   logic [DIV_NW-1:0]         m2;
   logic                      div_start;
   logic                      div_done;
   logic [DIV_NW-1:0]         div_q;
   logic                      root_start;
   logic                      root_done;
   logic [SQRT_RW-1:0]        root_val;
   logic [STAT_W-1:0]         root_sat;
   logic                      out_load;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign d_in = polarity_ff
      ? DELTA_W'({1'b0, req_bus.background_luma}) - DELTA_W'({1'b0, req_bus.current_luma})
      : DELTA_W'({1'b0, req_bus.current_luma}) - DELTA_W'({1'b0, req_bus.background_luma});

   assign w_eff = (grid_width_ff == '0) ? GRID_W'(1) :
                  (grid_width_ff > GRID_W'(MAX_WIDTH)) ? GRID_W'(MAX_WIDTH) : grid_width_ff;
   assign h_eff = (grid_height_ff == '0) ? GRID_W'(1) :
                  (grid_height_ff > GRID_W'(MAX_HEIGHT)) ? GRID_W'(MAX_HEIGHT) : grid_height_ff;
   assign row_end   = GRID_W'(col_ff) >= (w_eff - GRID_W'(1));
   assign frame_end = row_end && (GRID_W'(row_ff) >= (h_eff - GRID_W'(1)));

   assign left_pair = pair_test(left_ff, d_ff, min_delta_ff);
   assign up_pair   = pair_test(up_ff, d_ff, min_delta_ff);
   assign left_use  = (col_ff != '0) && left_pair.ok;
   assign up_use    = (row_ff != '0) && up_pair.ok;

   always_comb begin
      case (state_ff)
         ST_SQ1:  mul_a = left_diff_ff;
         ST_SQ2:  mul_a = up_diff_ff;
         default: mul_a = {2'b00, d_ff[LUMA_W-1:0]};
      endcase
   end

   assign sum_sel = sel_ff ? DIV_NW'(pair_sum_ff) : DIV_NW'(pos_sum_ff);
   assign sq_sel  = sel_ff ? pair_sq_ff : DIV_NW'(pos_sq_ff);
   assign n_sel   = sel_ff ? pair_cnt_ff : DIFF_W'(pos_cnt_ff);
   assign m2      = DIV_NW'(mean_ff * mean_ff);

   assign div_start  = (state_ff == ST_MDIV_GO) || (state_ff == ST_QDIV_GO);
   assign root_start = (state_ff == ST_ROOT_GO);
   assign root_sat   = sat16(root_val);
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   tdfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((state_ff == ST_QDIV_GO) ? sq_sel : sum_sel),
      .divisor  (n_sel),
      .done     (div_done),
      .quotient (div_q)
   );

   tdfs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({1'b0, var_ff}),
      .done     (root_done),
      .root     (root_val)
   );

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         up_ff <= row_mem[col_ff];
      end
      if (state_ff == ST_READ) begin
         row_mem[col_ff] <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= GRID_W'(64);
         grid_height_ff  <= GRID_W'(64);
         polarity_ff     <= 1'b0;
         min_delta_ff    <= '0;
         spread_floor_ff <= STAT_W'(256);
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_GRID_WIDTH:   grid_width_ff   <= csr_bus.data[GRID_W-1:0];
            REG_GRID_HEIGHT:  grid_height_ff  <= csr_bus.data[GRID_W-1:0];
            REG_POLARITY:     polarity_ff     <= csr_bus.data[0];
            REG_MIN_DELTA:    min_delta_ff    <= csr_bus.data;
            REG_SPREAD_FLOOR: spread_floor_ff <= csr_bus.data[STAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         pos_sum_ff   <= '0;
         pos_sq_ff    <= '0;
         pos_cnt_ff   <= '0;
         pair_sum_ff  <= '0;
         pair_sq_ff   <= '0;
         pair_cnt_ff  <= '0;
         sel_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (d_ff > 0) begin
                  pos_sum_ff <= pos_sum_ff + 32'(d_ff[LUMA_W-1:0]);
                  pos_cnt_ff <= pos_cnt_ff + 1'b1;
               end
               pair_sum_ff <= pair_sum_ff
                  + (left_use ? 33'(left_pair.diff) : 33'd0)
                  + (up_use ? 33'(up_pair.diff) : 33'd0);
               pair_cnt_ff <= pair_cnt_ff + DIFF_W'(left_use) + DIFF_W'(up_use);
               last_ff <= frame_end;
               left_ff <= frame_end ? '0 : d_ff;
               if (frame_end) begin
                  col_ff <= '0;
                  row_ff <= '0;
               end else if (row_end) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
               state_ff <= ST_SQ0;
            end
            ST_SQ0: state_ff <= ST_SQ1;
            ST_SQ1: begin
               if (d_ff > 0) begin
                  pos_sq_ff <= pos_sq_ff + 48'(prod_ff);
               end
               state_ff <= ST_SQ2;
            end
            ST_SQ2: begin
               if (left_ok_ff) begin
                  pair_sq_ff <= pair_sq_ff + 49'(prod_ff);
               end
               state_ff <= ST_SQ3;
            end
            ST_SQ3: begin
               if (up_ok_ff) begin
                  pair_sq_ff <= pair_sq_ff + 49'(prod_ff);
               end
               sel_ff   <= 1'b0;
               state_ff <= last_ff ? ST_MDIV_GO : ST_OUT;
            end
            ST_MDIV_GO: state_ff <= ST_MDIV;
            ST_MDIV: begin
               if (div_done) begin
                  state_ff <= ST_QDIV_GO;
               end
            end
            ST_QDIV_GO: state_ff <= ST_QDIV;
            ST_QDIV: begin
               if (div_done) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL:     state_ff <= ST_ROOT_GO;
            ST_ROOT_GO: state_ff <= ST_ROOT;
            ST_ROOT: begin
               if (root_done) begin
                  if (sel_ff) begin
                     state_ff <= ST_OUT;
                  end else begin
                     sel_ff   <= 1'b1;
                     state_ff <= ST_MDIV_GO;
                  end
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  if (last_ff) begin
                     pos_sum_ff  <= '0;
                     pos_sq_ff   <= '0;
                     pos_cnt_ff  <= '0;
                     pair_sum_ff <= '0;
                     pair_sq_ff  <= '0;
                     pair_cnt_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         d_ff <= d_in;
      end
      if (state_ff == ST_READ) begin
         left_ok_ff   <= left_use;
         up_ok_ff     <= up_use;
         left_diff_ff <= left_pair.diff;
         up_diff_ff   <= up_pair.diff;
      end
      prod_ff <= mul_a * mul_a;
      if ((state_ff == ST_MDIV) && div_done) begin
         mean_ff <= (n_sel != '0) ? div_q[DIFF_W-1:0] : '0;
      end
      if ((state_ff == ST_QDIV) && div_done) begin
         ex2_ff <= div_q;
      end
      if (state_ff == ST_MUL) begin
         var_ff <= ((n_sel > DIFF_W'(1)) && (ex2_ff > m2)) ? ex2_ff - m2 : '0;
      end
      if ((state_ff == ST_ROOT) && root_done) begin
         if (sel_ff) begin
            cmean_ff <= sat16(SQRT_RW'(mean_ff));
            cstd_ff  <= root_sat;
         end else begin
            dmean_ff <= sat16(SQRT_RW'(mean_ff));
            dnorm_ff <= (root_sat < spread_floor_ff) ? spread_floor_ff : root_sat;
         end
      end
      if (out_load) begin
         rsp_delta_ff <= d_ff;
         rsp_stats_ff <= last_ff;
         rsp_count_ff <= last_ff ? pos_cnt_ff : '0;
         rsp_dmean_ff <= last_ff ? dmean_ff : '0;
         rsp_dnorm_ff <= last_ff ? dnorm_ff : '0;
         rsp_cmean_ff <= last_ff ? cmean_ff : '0;
         rsp_cstd_ff  <= last_ff ? cstd_ff : '0;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.cell_delta     = rsp_delta_ff;
   assign rsp_bus.stats_valid    = rsp_stats_ff;
   assign rsp_bus.positive_count = rsp_count_ff;
   assign rsp_bus.pos_mean       = rsp_dmean_ff;
   assign rsp_bus.pos_spread     = rsp_dnorm_ff;
   assign rsp_bus.contrast_mean  = rsp_cmean_ff;
   assign rsp_bus.contrast_std   = rsp_cstd_ff;
endmodule

### src/tdfs_checker.sv
// Port-level checks on the thermal delta frame statistics core, with its bind.
module tdfs_checker
   import tdfs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               stats_valid,
   input logic [DELTA_W-1:0] positive_count,
   input logic [STAT_W-1:0]  pos_mean,
   input logic [STAT_W-1:0]  pos_spread,
   input logic [STAT_W-1:0]  contrast_mean,
   input logic [STAT_W-1:0]  contrast_std
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !stats_valid |-> positive_count == '0 && pos_mean == '0
         && pos_spread == '0 && contrast_mean == '0 && contrast_std == '0)
      else $error("statistics fields set on an ordinary cell");

   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stats_valid && positive_count == '0 |-> pos_mean == '0)
      else $error("non-zero mean with no positive cells");
endmodule

bind thermal_delta_frame_stats_core tdfs_checker u_tdfs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .stats_valid    (rsp_bus.stats_valid),
   .positive_count (rsp_bus.positive_count),
   .pos_mean       (rsp_bus.pos_mean),
   .pos_spread     (rsp_bus.pos_spread),
   .contrast_mean  (rsp_bus.contrast_mean),
   .contrast_std   (rsp_bus.contrast_std)
);

### bench/tb_top.sv
// Testbench for the thermal delta frame statistics core: directed and random cells checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
   import tdfs_pkg::*;

   typedef struct packed {
      logic signed [DELTA_W-1:0] cell_delta;
      logic                      stats_valid;
      logic [DELTA_W-1:0]        positive_count;
      logic [STAT_W-1:0]         pos_mean;
      logic [STAT_W-1:0]         pos_spread;
      logic [STAT_W-1:0]         contrast_mean;
      logic [STAT_W-1:0]         contrast_std;
   } cell_result_type;

   class stats_board_type;
      cell_result_type expected_results[$];
      int              mismatches;
      int              frames_seen;
      int              pair_frames;
      logic [GRID_W-1:0] grid_w;
      logic [GRID_W-1:0] grid_h;
      bit              cold_bright;
      int              min_delta;
      int              spread_floor;
      int              prev_row[MAX_WIDTH];
      int              left_delta;
      int              col_idx;
      int              row_idx;
      longint          pos_sum;
      longint          pos_sq_sum;
      longint          pos_cells;
      longint          pair_sum;
      longint          pair_sq_sum;
      longint          pair_cnt;

      function void clear_frame();
         left_delta  = 0;
         col_idx     = 0;
         row_idx     = 0;
         pos_sum     = 0;
         pos_sq_sum  = 0;
         pos_cells   = 0;
         pair_sum    = 0;
         pair_sq_sum = 0;
         pair_cnt    = 0;
      endfunction

      function void reset_state();
         grid_w       = GRID_W'(64);
         grid_h       = GRID_W'(64);
         cold_bright  = 1'b0;
         min_delta    = 0;
         spread_floor = 256;
         foreach (prev_row[i]) prev_row[i] = 0;
         clear_frame();
      endfunction

      function void write_reg(csr_reg_type idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            REG_GRID_WIDTH:   grid_w = data[GRID_W-1:0];
            REG_GRID_HEIGHT:  grid_h = data[GRID_W-1:0];
            REG_POLARITY:     cold_bright = data[0];
            REG_MIN_DELTA:    min_delta = int'($signed(data));
            REG_SPREAD_FLOOR: spread_floor = int'(data[15:0]);
            default: ;
         endcase
      endfunction

      function bit frame_start();
         return col_idx == 0 && row_idx == 0;
      endfunction

      function longint root_floor(longint v);
         longint r;
         longint cand;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v) r = cand;
         end
         return r;
      endfunction

      function longint sat(longint v);
         return v > 65535 ? 65535 : v;
      endfunction

      function void add_pair(int a, int b);
         int hi;
         int lo;
         int lim;
         if (a < min_delta || b < min_delta) return;
         hi  = a > b ? a : b;
         lo  = a > b ? b : a;
         lim = hi > 256 ? hi : 256;
         if (25 * longint'(lo) < 18 * longint'(lim)) return;
         pair_sum    += hi - lo;
         pair_sq_sum += longint'(hi - lo) * longint'(hi - lo);
         pair_cnt++;
      endfunction

      function void mean_dev(longint s, longint sq, longint n, output longint m,
                             output longint sd);
         longint v;
         longint ex2;
         m = 0;
         v = 0;
         if (n > 0) m = s / n;
         if (n > 1) begin
            ex2 = sq / n;
            v = ex2 > m * m ? ex2 - m * m : 0;
         end
         sd = sat(root_floor(v));
         m  = sat(m);
      endfunction

      function void note_cell(logic [LUMA_W-1:0] bg, logic [LUMA_W-1:0] cur);
         cell_result_type e;
         int w;
         int h;
         int d;
         bit row_end;
         longint m;
         longint sd;
         w = grid_w == 0 ? 1 : (grid_w > MAX_WIDTH ? MAX_WIDTH : int'(grid_w));
         h = grid_h == 0 ? 1 : (grid_h > MAX_HEIGHT ? MAX_HEIGHT : int'(grid_h));
         d = cold_bright ? int'(bg) - int'(cur) : int'(cur) - int'(bg);
         if (d > 0) begin
            pos_sum    += d;
            pos_sq_sum += longint'(d) * longint'(d);
            pos_cells++;
         end
         if (col_idx > 0) add_pair(left_delta, d);
         if (row_idx > 0) add_pair(prev_row[col_idx], d);
         prev_row[col_idx] = d;
         left_delta = d;
         e = '{default: '0};
         e.cell_delta = d[DELTA_W-1:0];
         row_end = col_idx >= w - 1;
         if (row_end && row_idx >= h - 1) begin
            e.stats_valid    = 1'b1;
            e.positive_count = pos_cells[DELTA_W-1:0];
            mean_dev(pos_sum, pos_sq_sum, pos_cells, m, sd);
            if (sd < spread_floor) sd = spread_floor;
            e.pos_mean   = m[15:0];
            e.pos_spread = sd[15:0];
            mean_dev(pair_sum, pair_sq_sum, pair_cnt, m, sd);
            e.contrast_mean = m[15:0];
            e.contrast_std  = sd[15:0];
            frames_seen++;
            if (pair_cnt > 1) pair_frames++;
            clear_frame();
         end else if (row_end) begin
            col_idx = 0;
            row_idx++;
         end else begin
            col_idx++;
         end
         expected_results.push_back(e);
      endfunction

      function void check_result(cell_result_type got);
         cell_result_type e;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: unexpected result, delta %0d", $time,
                                           got.cell_delta);
            return;
         end
         e = expected_results.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch", $time);
               $display("  exp delta %0d sv %0d cnt %0d mean %0d sprd %0d cm %0d cs %0d",
                        e.cell_delta, e.stats_valid, e.positive_count, e.pos_mean,
                        e.pos_spread, e.contrast_mean, e.contrast_std);
               $display("  got delta %0d sv %0d cnt %0d mean %0d sprd %0d cm %0d cs %0d",
                        got.cell_delta, got.stats_valid, got.positive_count, got.pos_mean,
                        got.pos_spread, got.contrast_mean, got.contrast_std);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   tdfs_req_if req_bus ();
   tdfs_rsp_if rsp_bus ();
   tdfs_csr_if csr_bus ();

   thermal_delta_frame_stats_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   stats_board_type board;
   bit quiet_phase;
   int cells_sent;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_cell(logic [LUMA_W-1:0] bg, logic [LUMA_W-1:0] cur);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid           = 1'b1;
      req_bus.background_luma = bg;
      req_bus.current_luma    = cur;
      do @(posedge clock); while (!req_bus.ready);
      board.note_cell(bg, cur);
      cells_sent++;
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      req_bus.valid = 1'b0;
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_all(int w, int h, bit bh, int md, int nf);
      drain();
      write_reg(REG_GRID_WIDTH, CSR_DAT_W'(w));
      write_reg(REG_GRID_HEIGHT, CSR_DAT_W'(h));
      write_reg(REG_POLARITY, CSR_DAT_W'(bh));
      write_reg(REG_MIN_DELTA, CSR_DAT_W'(md));
      write_reg(REG_SPREAD_FLOOR, CSR_DAT_W'(nf));
   endtask

   // mostly a smooth delta field so that pairs pass the ratio test
   task automatic send_shaped(bit smooth, int base);
      int bg;
      int d;
      bg = $urandom_range(0, 65535);
      if (!smooth) begin
         send_cell(LUMA_W'($urandom), LUMA_W'($urandom));
         return;
      end
      d = base + $urandom_range(0, base / 8 + 20) - (base / 16 + 10);
      if (board.cold_bright) d = -d;
      d = bg + d;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      send_cell(LUMA_W'(bg), LUMA_W'(d));
   endtask

   task automatic send_frames(int nframes, bit smooth);
      int base;
      for (int f = 0; f < nframes; f++) begin
         base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(200, 4000);
         do send_shaped(smooth, base); while (!board.frame_start());
      end
   endtask

   initial begin
      cell_result_type got;
      rsp_bus.ready = 1'b0;
      forever begin
         int stall;
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.cell_delta     = rsp_bus.cell_delta;
            got.stats_valid    = rsp_bus.stats_valid;
            got.positive_count = rsp_bus.positive_count;
            got.pos_mean       = rsp_bus.pos_mean;
            got.pos_spread     = rsp_bus.pos_spread;
            got.contrast_mean  = rsp_bus.contrast_mean;
            got.contrast_std   = rsp_bus.contrast_std;
            board.check_result(got);
         end
         @(negedge clock);
         stall = reset ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
      end
   end

   initial begin
      #20ms;
      $display("Timeout at %0t", $time);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int w;
      int h;
      int md;
      int nf;
      int r;
      board = new();
      board.reset_state();
      quiet_phase             = 1'b0;
      cells_sent              = 0;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.background_luma = '0;
      req_bus.current_luma    = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.index           = REG_GRID_WIDTH;
      csr_bus.data            = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, both polarities, negative threshold, clamped grid sizes
      set_all(3, 2, 0, 0, 256);
      send_cell(16'h0000, 16'hFFFF);
      send_cell(16'hFFFF, 16'h0000);
      send_cell(16'h0000, 16'h0000);
      send_cell(16'h1000, 16'h1500);
      send_cell(16'h1000, 16'h1480);
      send_cell(16'hFFFF, 16'hFFFF);
      set_all(2, 2, 1, -65535, 65535);
      send_cell(16'h0500, 16'h0100);
      send_cell(16'h0500, 16'h0120);
      send_cell(16'hFFFF, 16'h0000);
      send_cell(16'h0000, 16'hFFFF);
      set_all(0, 0, 0, 65535, 0);
      send_cell(16'h1234, 16'h5678);
      send_cell(16'h5678, 16'h1234);
      set_all(4, 3, 0, 256, 0);
      send_cell(16'h0100, 16'h0300);
      send_cell(16'h0100, 16'h0320);
      // narrow the grid partway through a frame
      drain();
      write_reg(REG_GRID_WIDTH, CSR_DAT_W'(1));
      write_reg(REG_GRID_HEIGHT, CSR_DAT_W'(2));
      send_cell(16'h0100, 16'h0310);
      send_cell(16'h0100, 16'h0330);
      while (!board.frame_start()) send_cell(16'h0100, 16'h0340);

      while (cells_sent < 1450) begin
         r = cells_sent > 1100 ? 19 : $urandom_range(0, 19);
         case (r)
            0: begin w = 256; h = $urandom_range(1, 2); end
            1: begin w = 1; h = 256; end
            2: begin w = $urandom_range(257, 511); h = 1; end
            3: begin w = 0; h = $urandom_range(0, 3); end
            default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 6); end
         endcase
         r = $urandom_range(0, 7);
         md = r == 0 ? -65535 : r == 1 ? 65535 : r == 2 ? int'($urandom_range(0, 131071)) - 65536
            : r < 5 ? 0 : $urandom_range(0, 400);
         r = $urandom_range(0, 5);
         nf = r == 0 ? 0 : r == 1 ? 65535 : $urandom_range(0, 2000);
         quiet_phase = ($urandom_range(0, 4) == 0);
         set_all(w, h, $urandom_range(0, 1), md, nf);
         if (w * h > 64 || w > 256) send_frames(1, $urandom_range(0, 3) != 0);
         else send_frames($urandom_range(1, 4), $urandom_range(0, 4) != 0);
         if ($urandom_range(0, 9) == 0 && board.grid_h > 1 && board.grid_w <= 8) begin
            send_shaped(1, 500);
            drain();
            write_reg(REG_GRID_HEIGHT, CSR_DAT_W'($urandom_range(1, 8)));
            write_reg(REG_GRID_WIDTH, CSR_DAT_W'($urandom_range(1, board.grid_w)));
            while (!board.frame_start()) send_shaped(1, 500);
         end
      end

      quiet_phase = 1'b0;
      drain();
      repeat (300) @(posedge clock);
      $display("%0d cells in %0d frames (%0d with two or more contrast pairs)",
               cells_sent, board.frames_seen, board.pair_frames);
      $display("%0d mismatches, %0d results outstanding", board.mismatches,
               board.expected_results.size());
      if (board.mismatches == 0 && board.expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
